FILE: sv/bsp_pkg.sv
// Shared types and constants for the SFLV stream parser.
// No dependencies; every other file imports this package.
package bsp_pkg;

    localparam int DEF_MAX_DEPTH = 16;
    localparam int DEF_POS_BITS  = 32;
    localparam int POS_MAX_BITS  = 48;
    localparam int DEPTH_MAX_BITS = 7;

    typedef enum logic [2:0] {
        PH_SEQ  = 3'd0,
        PH_FMT  = 3'd1,
        PH_LEN  = 3'd2,
        PH_INT  = 3'd3,
        PH_STR  = 3'd4,
        PH_ENUM = 3'd5,
        PH_SKIP = 3'd6,
        PH_BOOL = 3'd7
    } t_phase;

    localparam logic [2:0] K_HEADER = 3'd0;
    localparam logic [2:0] K_INT    = 3'd1;
    localparam logic [2:0] K_BOOL   = 3'd2;
    localparam logic [2:0] K_ENUM   = 3'd3;
    localparam logic [2:0] K_STRB   = 3'd4;
    localparam logic [2:0] K_CUT    = 3'd5;
    localparam logic [2:0] K_ENDED  = 3'd6;

    localparam logic [3:0] FMT_SET   = 4'd1;
    localparam logic [3:0] FMT_ARRAY = 4'd2;
    localparam logic [3:0] FMT_INT   = 4'd3;
    localparam logic [3:0] FMT_ENUM  = 4'd4;
    localparam logic [3:0] FMT_STR   = 4'd5;
    localparam logic [3:0] FMT_BOOL  = 4'd6;

    typedef struct packed {
        logic                    push;
        logic [POS_MAX_BITS-1:0] push_decl;
        logic [POS_MAX_BITS-1:0] push_close;
        logic                    done;
        logic                    clear;
        logic [POS_MAX_BITS-1:0] pos;
    } t_stk_ctl;

    typedef struct packed {
        logic [DEPTH_MAX_BITS-1:0] depth;
        logic [POS_MAX_BITS-1:0]   top_decl;
    } t_stk_sts;

    typedef struct packed {
        logic [1:0] cnt;
        logic [2:0] k0;
        logic [2:0] k1;
    } t_res;

endpackage

FILE: sv/bsp_stack.sv
// Container end stack of the SFLV parser, one compare lane per entry.
// Depends on bsp_pkg.
module bsp_stack #(
    parameter int MAX_DEPTH = bsp_pkg::DEF_MAX_DEPTH,
    parameter int POS_BITS  = bsp_pkg::DEF_POS_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bsp_pkg::t_stk_ctl i_ctl,
    output bsp_pkg::t_stk_sts o_sts
);
    import bsp_pkg::*;

    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam int IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    logic [POS_BITS-1:0] r_decl  [MAX_DEPTH];
    logic [POS_BITS-1:0] r_close [MAX_DEPTH];
    logic [DW-1:0]       r_depth;
    logic [DW-1:0]       n_depth;
    logic [DW-1:0]       depth_m1;
    logic [DW-1:0]       depth_p;
    logic [POS_BITS-1:0] pos;
    logic [POS_BITS-1:0] pdecl;
    logic [POS_BITS-1:0] pclose;
    logic [MAX_DEPTH-1:0] open;

    assign pos      = i_ctl.pos[POS_BITS-1:0];
    assign pdecl    = i_ctl.push_decl[POS_BITS-1:0];
    assign pclose   = i_ctl.push_close[POS_BITS-1:0];
    assign depth_m1 = r_depth - DW'(1);
    assign depth_p  = r_depth + DW'(i_ctl.push);

    // Each lane tells whether its container is still open at the new position,
    // with a same-cycle push taken into account.
    always_comb begin
        for (int d = 0; d < MAX_DEPTH; d++) begin
            if (i_ctl.push && (DW'(d) == r_depth)) begin
                open[d] = (pos < pdecl) && (pos < pclose);
            end else begin
                open[d] = (pos < r_decl[d]) && (pos < r_close[d]);
            end
        end
    end

    always_comb begin
        n_depth = depth_p;
        if (i_ctl.done) begin
            n_depth = '0;
            for (int d = 0; d < MAX_DEPTH; d++) begin
                if ((DW'(d) < depth_p) && open[d]) begin
                    n_depth = DW'(d + 1);
                end
            end
        end
        if (i_ctl.clear) begin
            n_depth = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
        end else begin
            r_depth <= n_depth;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_decl[r_depth[IW-1:0]]  <= pdecl;
            r_close[r_depth[IW-1:0]] <= pclose;
        end
    end

    assign o_sts.depth    = DEPTH_MAX_BITS'(r_depth);
    assign o_sts.top_decl = POS_MAX_BITS'(r_decl[depth_m1[IW-1:0]]);

endmodule

FILE: sv/bsp_parser.sv
// Per-byte SFLV parse step with its state registers.
// Depends on bsp_pkg; drives the end stack through t_stk_ctl.
module bsp_parser #(
    parameter int MAX_DEPTH = bsp_pkg::DEF_MAX_DEPTH,
    parameter int POS_BITS  = bsp_pkg::DEF_POS_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    input  bsp_pkg::t_stk_sts i_sts,
    output bsp_pkg::t_stk_ctl o_ctl,
    output bsp_pkg::t_res     o_res
);
    import bsp_pkg::*;

    localparam int DW = $clog2(MAX_DEPTH + 1);

    t_phase              r_phase, n_phase;
    logic [POS_BITS-1:0] r_pos, n_pos;
    logic [63:0]         r_acc, n_acc;
    logic [6:0]          r_shift, n_shift;
    logic [3:0]          r_fmt, n_fmt;
    logic [63:0]         r_rem, n_rem;

    logic [DW-1:0]       depth;
    logic [POS_BITS-1:0] decl;
    logic                at_end;
    logic                fit;
    logic [POS_BITS-1:0] cend;
    logic [63:0]         acc_f;
    logic [6:0]          shift_f;
    logic                vdone;
    logic [63:0]         rem_dec;
    logic                a_v, b_v, c_v;
    logic [2:0]          a_k, b_k, c_k;
    logic                push, done;
    logic [POS_BITS-1:0] push_close;

    assign n_pos  = r_pos + POS_BITS'(1);
    assign depth  = i_sts.depth[DW-1:0];
    assign decl   = i_sts.top_decl[POS_BITS-1:0];
    assign at_end = (depth != '0) && (n_pos >= decl);
    assign fit    = (depth == '0) ||
                    ((decl >= n_pos) && (acc_f <= 64'(decl - n_pos)));
    assign cend   = (acc_f > 64'(~n_pos)) ? '1 : n_pos + acc_f[POS_BITS-1:0];
    assign rem_dec = (r_rem != '0) ? r_rem - 64'd1 : r_rem;
    assign push_close = (depth != '0) ? decl : cend;

    // Varint group: overflowing bits end the varint with value zero.
    always_comb begin
        acc_f   = r_acc;
        shift_f = r_shift;
        vdone   = 1'b0;
        if (r_shift[6]) begin
            if (i_byte[6:0] != 7'd0) begin
                acc_f = '0;
                vdone = 1'b1;
            end
        end else begin
            acc_f = r_acc | (64'(i_byte[6:0]) << r_shift[5:0]);
        end
        if (!vdone) begin
            vdone = !i_byte[7];
            if (r_shift[6] || (r_shift + 7'd7 >= 7'd64)) begin
                shift_f = 7'd64;
            end else begin
                shift_f = r_shift + 7'd7;
            end
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_shift = r_shift;
        n_fmt   = r_fmt;
        n_rem   = r_rem;
        a_v = 1'b0; a_k = K_HEADER;
        b_v = 1'b0; b_k = K_HEADER;
        c_v = 1'b0; c_k = K_CUT;
        push = 1'b0;
        done = 1'b0;
        case (r_phase)
            PH_SEQ: begin
                n_acc   = acc_f;
                n_shift = shift_f;
                if (vdone) begin
                    if (at_end) begin
                        a_v = 1'b1; a_k = K_CUT; done = 1'b1;
                    end else begin
                        n_phase = PH_FMT;
                    end
                end else if (at_end) begin
                    a_v = 1'b1; a_k = K_CUT; done = 1'b1;
                end
            end
            PH_FMT: begin
                n_fmt = i_byte[3:0];
                if (at_end) begin
                    a_v = 1'b1; a_k = K_CUT; done = 1'b1;
                end else begin
                    n_acc = '0; n_shift = '0; n_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                n_acc   = acc_f;
                n_shift = shift_f;
                if (vdone) begin
                    a_v = 1'b1; a_k = K_HEADER;
                    case (r_fmt)
                        FMT_SET, FMT_ARRAY: begin
                            if (depth >= DW'(MAX_DEPTH)) begin
                                if (acc_f == '0) begin
                                    done = 1'b1;
                                end else begin
                                    n_rem = acc_f; n_phase = PH_SKIP;
                                end
                            end else begin
                                push = 1'b1; done = 1'b1;
                            end
                        end
                        FMT_INT: begin
                            if ((acc_f == '0) || !fit) begin
                                b_v = 1'b1; b_k = K_INT; done = 1'b1;
                            end else begin
                                n_rem = acc_f; n_phase = PH_INT;
                            end
                        end
                        FMT_ENUM: begin
                            if (at_end) begin
                                b_v = 1'b1; b_k = K_ENUM; done = 1'b1;
                            end else begin
                                n_acc = '0; n_shift = '0; n_phase = PH_ENUM;
                            end
                        end
                        FMT_STR: begin
                            if ((acc_f == '0) || !fit) begin
                                done = 1'b1;
                            end else begin
                                n_rem = acc_f; n_phase = PH_STR;
                            end
                        end
                        FMT_BOOL: begin
                            if (at_end) begin
                                done = 1'b1;
                            end else begin
                                n_phase = PH_BOOL;
                            end
                        end
                        default: begin
                            if (acc_f == '0) begin
                                done = 1'b1;
                            end else begin
                                n_rem = acc_f; n_phase = PH_SKIP;
                            end
                        end
                    endcase
                end else if (at_end) begin
                    a_v = 1'b1; a_k = K_CUT; done = 1'b1;
                end
            end
            PH_INT: begin
                n_rem = rem_dec;
                if (rem_dec == '0) begin
                    a_v = 1'b1; a_k = K_INT; done = 1'b1;
                end
            end
            PH_STR: begin
                n_rem = rem_dec;
                a_v = 1'b1; a_k = K_STRB;
                if (rem_dec == '0) begin
                    done = 1'b1;
                end
            end
            PH_ENUM: begin
                n_acc   = acc_f;
                n_shift = shift_f;
                if (vdone || at_end) begin
                    a_v = 1'b1; a_k = K_ENUM; done = 1'b1;
                end
            end
            PH_SKIP: begin
                n_rem = rem_dec;
                if (rem_dec == '0) begin
                    done = 1'b1;
                end
            end
            default: begin
                a_v = 1'b1; a_k = K_BOOL; done = 1'b1;
            end
        endcase
        if (done) begin
            n_phase = PH_SEQ; n_acc = '0; n_shift = '0;
        end
        if (i_last) begin
            if (n_phase == PH_SEQ) begin
                c_v = (n_shift != '0);
            end else begin
                c_v = 1'b1;
                c_k = (n_phase <= PH_LEN) ? K_CUT : K_ENDED;
            end
        end
    end

    // At most two results are kept, in header, value, end-of-stream order.
    always_comb begin
        o_res.cnt = '0;
        o_res.k0  = a_k;
        o_res.k1  = b_k;
        if (a_v) begin
            o_res.k0 = a_k;
            if (b_v) begin
                o_res.k1 = b_k; o_res.cnt = 2'd2;
            end else if (c_v) begin
                o_res.k1 = c_k; o_res.cnt = 2'd2;
            end else begin
                o_res.cnt = 2'd1;
            end
        end else if (b_v) begin
            o_res.k0 = b_k;
            o_res.k1 = c_k;
            o_res.cnt = c_v ? 2'd2 : 2'd1;
        end else if (c_v) begin
            o_res.k0 = c_k; o_res.cnt = 2'd1;
        end
        if (!i_en) begin
            o_res.cnt = '0;
        end
    end

    assign o_ctl.push       = i_en && push && !i_last;
    assign o_ctl.push_decl  = POS_MAX_BITS'(cend);
    assign o_ctl.push_close = POS_MAX_BITS'(push_close);
    assign o_ctl.done       = i_en && done;
    assign o_ctl.clear      = i_en && i_last;
    assign o_ctl.pos        = POS_MAX_BITS'(n_pos);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_en && i_last)) begin
            r_phase <= PH_SEQ;
            r_pos   <= '0;
            r_acc   <= '0;
            r_shift <= '0;
            r_fmt   <= '0;
            r_rem   <= '0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_acc   <= n_acc;
            r_shift <= n_shift;
            r_fmt   <= n_fmt;
            r_rem   <= n_rem;
        end
    end

endmodule

FILE: sv/bsp_fifo.sv
// Four-entry result queue taking up to two kinds a cycle, giving one unless stalled.
// Depends on bsp_pkg.
module bsp_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bsp_pkg::t_res i_res,
    output logic          o_valid,
    output logic [2:0]    o_kind,
    input  logic          i_stall,
    output logic          o_full,
    output logic [2:0]    o_count
);
    import bsp_pkg::*;

    logic [2:0] r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_count;
    logic       pop;

    assign o_valid = (r_count != 3'd0);
    assign pop     = o_valid && !i_stall;
    assign o_kind  = r_mem[r_rp];
    assign o_full  = (r_count > 3'd2);
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= r_wp + i_res.cnt;
            r_rp    <= r_rp + 2'(pop);
            r_count <= r_count + 3'(i_res.cnt) - 3'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res.cnt != 2'd0) begin
            r_mem[r_wp] <= i_res.k0;
        end
        if (i_res.cnt == 2'd2) begin
            r_mem[r_wp + 2'd1] <= i_res.k1;
        end
    end

endmodule

FILE: sv/bej_sflv_stream_parser_top.sv
// SFLV stream parser top level: one byte per request, one kind per result request.
// Results: an accepted byte's kinds enter the queue behind any earlier ones.
// Throughput: one byte per cycle; a byte is refused while the result queue
// holds more than two kinds, so only a stalled output side slows it down.
// Reset: synchronous, active low; a taken last byte also clears parser and stack.
// Depends on bsp_pkg, bsp_stack, bsp_parser and bsp_fifo.
module bej_sflv_stream_parser_top #(
    parameter int MAX_DEPTH = bsp_pkg::DEF_MAX_DEPTH,
    parameter int POS_BITS  = bsp_pkg::DEF_POS_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_stall,
    output logic       o_valid,
    output logic [2:0] o_kind,
    input  logic       i_stall
);
    import bsp_pkg::*;

    // The parser does all of a byte's work in the cycle it is accepted: the
    // state registers update and up to two result kinds enter the queue.
    // Container ends live in a small stack whose lanes each compare their
    // own end against the new position, so several nested containers can
    // close at once, within the parse step of a single byte.

    t_stk_ctl   stk_ctl;
    t_stk_sts   stk_sts;
    t_res       res;
    logic       full;
    logic [2:0] count;
    logic       accept;

    assign o_stall = full;
    assign accept  = i_valid && !full;

    bsp_stack #(.MAX_DEPTH(MAX_DEPTH), .POS_BITS(POS_BITS)) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (stk_ctl),
        .o_sts   (stk_sts)
    );

    bsp_parser #(.MAX_DEPTH(MAX_DEPTH), .POS_BITS(POS_BITS)) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (accept),
        .i_byte  (i_data_byte),
        .i_last  (i_last_byte),
        .i_sts   (stk_sts),
        .o_ctl   (stk_ctl),
        .o_res   (res)
    );

    bsp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (res),
        .o_valid (o_valid),
        .o_kind  (o_kind),
        .i_stall (i_stall),
        .o_full  (full),
        .o_count (count)
    );

    // The queue can never overflow its four entries.
    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        count <= 3'd4) else $error("result queue overflow");

    // A byte marked last leaves no container open.
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_last_byte) |=> (stk_sts.depth == '0))
        else $error("stack not cleared after last byte");

    // Nesting never exceeds the configured depth.
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stk_sts.depth <= DEPTH_MAX_BITS'(MAX_DEPTH))
        else $error("stack depth out of range");

    // No result enters the queue without an accepted byte.
    a_no_idle_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |-> (res.cnt == 2'd0)) else $error("result without request");

endmodule
